@@ rtl/arip_pkg.sv @@
// ----------------------------------------------------------------------------
// arip_pkg
// shared types, character codes and digit decode for the integer parser
// ----------------------------------------------------------------------------
package arip_pkg;

    localparam int VALUE_W = 32;
    localparam int BASE_W  = 6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
    localparam logic [BASE_W-1:0] BASE_DEFAULT = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] NOT_A_DIGIT  = 6'd36;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    // one queued operation for the accumulator side
    typedef struct packed {
        logic              mac;
        logic [BASE_W-1:0] digit;
        logic [BASE_W-1:0] base;
        logic              last;
        logic              negative;
    } op_t;

    function automatic logic [BASE_W-1:0] digit_of(input logic [7:0] c);
        logic [BASE_W-1:0] d;
        d = NOT_A_DIGIT;
        if (c >= CH_0 && c <= CH_9) begin
            d = BASE_W'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = BASE_W'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = BASE_W'(c - CH_UA + 8'd10);
        end
        return d;
    endfunction

endpackage

@@ rtl/arip_front.sv @@
// ----------------------------------------------------------------------------
// arip_front
// character classifier: whitespace, sign, hex prefix and digit phases
// ----------------------------------------------------------------------------
module arip_front
    import arip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] character,
    input  logic [7:0] radix,
    input  logic       last,
    output logic       push,
    output op_t        push_op
);

    phase_t phase_reg, phase_next, phase_upd;
    logic   negative_reg, negative_next, negative_upd;

    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] digit;
    logic              is_digit;
    logic              mac;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SPACE;
            negative_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
        end
    end

    always_comb
    begin
        base = (radix < 8'(BASE_MIN) || radix > 8'(BASE_MAX)) ? BASE_DEFAULT
                                                               : radix[BASE_W-1:0];
        digit    = digit_of(character);
        is_digit = (character != CH_NUL) && (digit < base);

        phase_upd    = phase_reg;
        negative_upd = negative_reg;
        mac          = 1'b0;

        unique case (phase_reg)
            PH_SPACE, PH_SIGNED:
            begin
                if (phase_reg == PH_SPACE &&
                    (character == CH_SPACE || character == CH_TAB))
                begin
                    phase_upd = PH_SPACE;
                end
                else if (phase_reg == PH_SPACE && character == CH_MINUS)
                begin
                    negative_upd = 1'b1;
                    phase_upd    = PH_SIGNED;
                end
                else if (phase_reg == PH_SPACE && character == CH_PLUS)
                begin
                    phase_upd = PH_SIGNED;
                end
                else if (base == BASE_HEX && character == CH_0)
                begin
                    phase_upd = PH_ZERO;
                end
                else if (is_digit)
                begin
                    mac       = 1'b1;
                    phase_upd = PH_DIGITS;
                end
                else
                begin
                    phase_upd = PH_DONE;
                end
            end
            PH_ZERO:
            begin
                // the leading zero added nothing, so the accumulator is still zero
                if (character == CH_LX || character == CH_UX)
                begin
                    phase_upd = PH_DIGITS;
                end
                else if (is_digit)
                begin
                    mac       = 1'b1;
                    phase_upd = PH_DIGITS;
                end
                else
                begin
                    phase_upd = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    mac       = 1'b1;
                    phase_upd = PH_DIGITS;
                end
                else
                begin
                    phase_upd = PH_DONE;
                end
            end
            default:
            begin
                phase_upd = PH_DONE;
            end
        endcase

        phase_next    = phase_reg;
        negative_next = negative_reg;
        if (accept)
        begin
            phase_next    = last ? PH_SPACE : phase_upd;
            negative_next = last ? 1'b0 : negative_upd;
        end

        push             = accept && (mac || last);
        push_op.mac      = mac;
        push_op.digit    = digit;
        push_op.base     = base;
        push_op.last     = last;
        push_op.negative = negative_upd;
    end

endmodule

@@ rtl/arip_fifo.sv @@
// ----------------------------------------------------------------------------
// arip_fifo
// short operation queue between classifier and accumulator
// ----------------------------------------------------------------------------
module arip_fifo
    import arip_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign head_op = entry_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

@@ rtl/arip_back.sv @@
// ----------------------------------------------------------------------------
// arip_back
// accumulator: multiply-add per digit, sign and result register
// ----------------------------------------------------------------------------
module arip_back
    import arip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  op_t                head_op,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_value
);

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_valid_reg, out_valid_next;

    logic [VALUE_W-1:0] product;
    logic [VALUE_W-1:0] acc_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    always_comb
    begin
        // a final op waits only while the result register is held
        pop = head_valid && (!head_op.last || !out_valid_reg || out_ready);

        // only the low word is kept, so the product wraps modulo 2^32
        product = acc_reg * VALUE_W'(head_op.base);
        acc_upd = head_op.mac ? product + VALUE_W'(head_op.digit) : acc_reg;

        acc_next       = acc_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            acc_next = head_op.last ? '0 : acc_upd;
            if (head_op.last)
            begin
                out_value_next = head_op.negative ? (~acc_upd + 1'b1) : acc_upd;
                out_valid_next = 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

endmodule

@@ rtl/ascii_radix_integer_parser_top.sv @@
// ----------------------------------------------------------------------------
// ascii_radix_integer_parser_top
// streaming ascii-to-integer parser with selectable radix
// ----------------------------------------------------------------------------
// usage
//   input channel (s_*): one item per string character; tdata carries the
//   character byte and the radix, tlast marks the final character. a radix
//   outside 2..36 counts as 10.
//   output channel (m_*): one item per string, the signed 32-bit value
//   wrapped modulo 2^32; a string without digits gives zero.
// throughput and result path
//   one character per cycle sustained while the queue has room. the result
//   of a string reaches m_tvalid through the queue and the result register:
//   the classifier writes the queue at the edge that takes its last character,
//   then the multiply-add loads the result register from the queue head.
//   the rate is set by the single 32x6 multiply-add in the accumulator.
// reset
//   rst_n clears the parse phase, sign, accumulator, queue and result valid;
//   the block then waits for the first character of a new string.
// stall
//   while m_tready is low the result register holds; further strings are
//   parsed into the queue until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module ascii_radix_integer_parser_top
    import arip_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] character, [15:8] radix
    input  logic        s_tlast,    // last character of the string
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] value, signed
);

    logic accept;
    logic push;
    op_t  push_op;
    op_t  head_op;
    logic pop;
    logic empty;
    logic full;

    // no item is taken while the queue is full
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // front: phase tracking and per-character classification
    arip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .character (s_tdata[7:0]),
        .radix     (s_tdata[15:8]),
        .last      (s_tlast),
        .push      (push),
        .push_op   (push_op)
    );

    // queue: only digits and end-of-string markers are stored
    arip_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .empty   (empty),
        .full    (full)
    );

    // back: accumulate and emit the signed value
    arip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!empty),
        .head_op    (head_op),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata)
    );

endmodule

@@ bench/tb_ascii_radix_integer_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_radix_integer_parser_top
// self-checking bench for the streaming ascii-to-integer parser
// ----------------------------------------------------------------------------
// a short table of hand-picked strings goes first, then random strings, most
// of them well-formed numbers in a random radix, the rest noise. a parser
// model in the bench follows every accepted character and queues the value
// each string should give; the result side pops and compares. both sides
// take random gaps, with one long stretch at full rate.
// ----------------------------------------------------------------------------
module tb_ascii_radix_integer_parser_top;

    import arip_pkg::*;

    localparam int  HALF_PERIOD  = 5;
    localparam int  RESET_CYCLES = 12;
    localparam int  RANDOM_CHARS = 1650;
    localparam int  GAP_PERCENT  = 18;
    localparam int  STUCK_LIMIT  = 2000;
    localparam int  DRAIN_CYCLES = 10;
    localparam int  DIRECTED_N   = 28;

    // one row of the directed table; pinned rows carry their value by hand
    typedef struct packed {
        logic [7:0]  ch;
        logic [7:0]  rdx;
        logic        lst;
        logic        pinned;
        logic [31:0] value;
    } row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;   // [7:0] character, [15:8] radix
    logic        s_tlast  = 1'b0;       // last character of the string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;               // [31:0] value, signed

    // model state of the parser
    phase_t      prs_phase = PH_SPACE;
    logic        prs_neg   = 1'b0;
    logic [31:0] prs_acc   = 32'h0;

    logic [31:0] expected_values[$];
    logic [31:0] oldest_value;
    int          mismatch_count = 0;
    int          stuck_cycles   = 0;
    int          chars_sent     = 0;
    bit          no_gaps        = 1'b0;
    row_t        dir_rows [DIRECTED_N];

    ascii_radix_integer_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    // worth of a character as a digit, NOT_A_DIGIT when it is none
    function automatic logic [7:0] char_value(input logic [7:0] ch);
        logic [7:0] dv;
        dv = 8'(NOT_A_DIGIT);
        if (ch >= CH_0 && ch <= CH_9)
        begin
            dv = ch - CH_0;
        end
        else if (ch >= CH_LA && ch <= CH_LZ)
        begin
            dv = ch - CH_LA + 8'd10;
        end
        else if (ch >= CH_UA && ch <= CH_UZ)
        begin
            dv = ch - CH_UA + 8'd10;
        end
        return dv;
    endfunction

    task automatic take_digit(input logic [7:0] ch, input logic [7:0] base);
        logic [7:0] dv;
        dv = char_value(ch);
        if (ch == CH_NUL || dv >= base)
        begin
            prs_phase = PH_DONE;
        end
        else
        begin
            prs_acc   = prs_acc * 32'(base) + 32'(dv);
            prs_phase = PH_DIGITS;
        end
    endtask

    // first character after blanks and sign: a hex '0' may open a prefix
    task automatic take_first(input logic [7:0] ch, input logic [7:0] base);
        if (base == 8'(BASE_HEX) && ch == CH_0)
        begin
            prs_phase = PH_ZERO;
        end
        else
        begin
            take_digit(ch, base);
        end
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic [7:0] rdx, input logic lst,
                              output logic has_value, output logic [31:0] value);
        logic [7:0] base;
        base = (rdx < 8'(BASE_MIN) || rdx > 8'(BASE_MAX)) ? 8'(BASE_DEFAULT) : rdx;
        case (prs_phase)
            PH_SPACE:
            begin
                if (ch == CH_MINUS)
                begin
                    prs_neg   = 1'b1;
                    prs_phase = PH_SIGNED;
                end
                else if (ch == CH_PLUS)
                begin
                    prs_phase = PH_SIGNED;
                end
                else if (ch != CH_SPACE && ch != CH_TAB)
                begin
                    take_first(ch, base);
                end
            end
            PH_SIGNED: take_first(ch, base);
            PH_ZERO:
            begin
                // the leading zero added nothing to the accumulator
                if (ch == CH_LX || ch == CH_UX)
                begin
                    prs_phase = PH_DIGITS;
                end
                else
                begin
                    take_digit(ch, base);
                end
            end
            PH_DIGITS: take_digit(ch, base);
            default:   prs_phase = PH_DONE;
        endcase
        has_value = lst;
        value     = prs_neg ? (32'h0 - prs_acc) : prs_acc;
        if (lst)
        begin
            prs_phase = PH_SPACE;
            prs_neg   = 1'b0;
            prs_acc   = 32'h0;
        end
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offers one item after a random gap and returns at the edge that takes it;
    // a pinned value replaces the model's value in the queue
    task automatic send_char(input logic [7:0] ch, input logic [7:0] rdx, input logic lst,
                             input logic pinned, input logic [31:0] pinned_value);
        logic        has_value;
        logic [31:0] value;
        while (!no_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rdx, ch};
        s_tlast  <= lst;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        parse_char(ch, rdx, lst, has_value, value);
        if (has_value)
        begin
            expected_values.push_back(pinned ? pinned_value : value);
        end
        chars_sent++;
    endtask

    // one random string: mostly a well-formed number, sometimes pure noise
    task automatic send_random_string();
        logic [7:0] chars[$];
        logic [7:0] rads[$];
        logic [7:0] base;
        logic [7:0] eff;
        logic [7:0] dv;
        int         pick;
        int         n;
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
            base = 8'($urandom_range(0, 255));
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                base = 8'(BASE_DEFAULT);
            else if (pick < 5)
                base = 8'(BASE_HEX);
            else if (pick == 5)
                base = 8'($urandom_range(0, 255));
            else
                base = 8'($urandom_range(2, 36));
            eff = (base < 8'(BASE_MIN) || base > 8'(BASE_MAX)) ? 8'(BASE_DEFAULT) : base;
            // leading blanks
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            repeat (n)
            begin
                chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            end
            pick = $urandom_range(0, 2);
            if (pick == 1)
                chars.push_back(CH_MINUS);
            else if (pick == 2)
                chars.push_back(CH_PLUS);
            if (eff == 8'(BASE_HEX) && $urandom_range(0, 1))
            begin
                chars.push_back(CH_0);
                chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            // digits: usually few, now and then enough to wrap
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
            repeat (n)
            begin
                dv = 8'($urandom_range(0, eff - 1));
                if (dv < 8'd10)
                    chars.push_back(CH_0 + dv);
                else
                    chars.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + dv - 8'd10);
            end
            // a stop character and some trailing bytes
            if ($urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    chars.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (chars.size() == 0)
                chars.push_back(8'($urandom_range(0, 255)));
        end
        // the radix may switch in the middle of a string
        foreach (chars[i])
        begin
            rads.push_back(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : base);
        end
        foreach (chars[i])
        begin
            send_char(chars[i], rads[i], i == chars.size() - 1, 1'b0, 32'h0);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: check against the oldest queued value, random stalls
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch: %s, got %0d (0x%08h), want %0d (0x%08h)",
                 $time, what, $signed(got), got, $signed(want), want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_values.size() == 0)
                begin
                    report_mismatch("value with no string pending", m_tdata, 32'h0);
                end
                else
                begin
                    oldest_value = expected_values.pop_front();
                    if (m_tdata !== oldest_value)
                    begin
                        report_mismatch("value", m_tdata, oldest_value);
                    end
                end
            end
            m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PERCENT);
        end
    end

    // watchdog: too many cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[ascii_radix_integer_parser_top] ERROR");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        dir_rows = '{
            // blanks, minus sign
            '{CH_SPACE, 8'd10, 1'b0, 1'b0, 32'h0},
            '{CH_TAB,   8'd10, 1'b0, 1'b0, 32'h0},
            '{CH_MINUS, 8'd10, 1'b0, 1'b0, 32'h0},
            '{"7",      8'd10, 1'b1, 1'b1, -32'sd7},
            // plus sign, top letter in the widest radix
            '{CH_PLUS,  8'd36, 1'b0, 1'b0, 32'h0},
            '{"z",      8'd36, 1'b1, 1'b1, 32'd35},
            // hex prefix, lower case
            '{CH_0,     8'd16, 1'b0, 1'b0, 32'h0},
            '{CH_LX,    8'd16, 1'b0, 1'b0, 32'h0},
            '{"1",      8'd16, 1'b0, 1'b0, 32'h0},
            '{"F",      8'd16, 1'b1, 1'b1, 32'd31},
            // prefix alone, upper case
            '{CH_0,     8'd16, 1'b0, 1'b0, 32'h0},
            '{CH_UX,    8'd16, 1'b1, 1'b1, 32'd0},
            // lone zero in hex is a plain digit
            '{CH_0,     8'd16, 1'b0, 1'b0, 32'h0},
            '{"7",      8'd16, 1'b1, 1'b1, 32'd7},
            // bad radix at both ends of the byte range means ten
            '{"9",      8'd0,   1'b1, 1'b1, 32'd9},
            '{8'hFF,    8'hFF,  1'b1, 1'b1, 32'd0},
            // sign and no digits
            '{CH_MINUS, 8'd10, 1'b1, 1'b1, 32'd0},
            // nul stops parsing, later bytes ignored
            '{"5",      8'd10, 1'b0, 1'b0, 32'h0},
            '{CH_NUL,   8'd10, 1'b0, 1'b0, 32'h0},
            '{"3",      8'd10, 1'b1, 1'b1, 32'd5},
            // radix changes between characters
            '{"1",      8'd2,  1'b0, 1'b0, 32'h0},
            '{"1",      8'd16, 1'b1, 1'b0, 32'h0},
            // wraps past 2^31
            '{"z",      8'd36, 1'b0, 1'b0, 32'h0},
            '{"z",      8'd36, 1'b0, 1'b0, 32'h0},
            '{"Z",      8'd36, 1'b0, 1'b0, 32'h0},
            '{"z",      8'd36, 1'b0, 1'b0, 32'h0},
            '{"Z",      8'd36, 1'b0, 1'b0, 32'h0},
            '{"z",      8'd36, 1'b1, 1'b0, 32'h0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_char(dir_rows[i].ch, dir_rows[i].rdx, dir_rows[i].lst,
                      dir_rows[i].pinned, dir_rows[i].value);
        end

        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            // a long stretch at full rate on both sides
            no_gaps = (chars_sent >= 700 && chars_sent < 1000);
            send_random_string();
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("[ascii_radix_integer_parser_top] OK");
        end
        else
        begin
            $display("[ascii_radix_integer_parser_top] ERROR");
        end
        $finish;
    end

endmodule
